### hdl/psrl_pkg.sv
// ---------------------------------------------------------------------------
// psrl_pkg
// Shared types, codes and constants of the per-source window rate limiter.
// ---------------------------------------------------------------------------
package psrl_pkg;

  // default sizes of the tables
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int SHARD_COUNT_DEF   = 16;
  localparam int PROBE_DEPTH_DEF   = 8;
  localparam int GATE_WAYS_DEF     = 16;

  // hash and table geometry
  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam int HASH_SHIFT  = 22;
  localparam int HASH_BITS   = 32 - HASH_SHIFT;
  localparam int SHARD_SHIFT = 6;
  localparam int GATE_SETS   = 3;
  localparam int SET_W       = 2;
  localparam int CNT_W       = 17;
  localparam int TIME_W      = 48;
  localparam int KINDS       = 6;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [31:0]       DROP_MAX = '1;

  // event kinds
  localparam logic [2:0] KIND_OPEN  = 3'd0;
  localparam logic [2:0] KIND_PING  = 3'd1;
  localparam logic [2:0] KIND_ECHO  = 3'd2;
  localparam logic [2:0] KIND_MISS  = 3'd3;
  localparam logic [2:0] KIND_BAD   = 3'd4;
  localparam logic [2:0] KIND_CLOSE = 3'd5;

  // deny causes
  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_WINDOW = 2'd1;
  localparam logic [1:0] CAUSE_GATE   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_OPEN_LIMIT  = 3'd0;
  localparam logic [2:0] REG_ECHO_LIMIT  = 3'd1;
  localparam logic [2:0] REG_MISS_LIMIT  = 3'd2;
  localparam logic [2:0] REG_BAD_LIMIT   = 3'd3;
  localparam logic [2:0] REG_CLOSE_LIMIT = 3'd4;
  localparam logic [2:0] REG_WINDOW_LEN  = 3'd5;
  localparam int PADDR_W = 5;

  typedef struct packed {
    logic [2:0]        kind;
    logic [31:0]       source_addr;
    logic [TIME_W-1:0] timestamp;
  } item_in_t;

  typedef struct packed {
    logic        allowed;
    logic [1:0]  deny_cause;
    logic [31:0] drops_so_far;
  } result_t;

  typedef struct packed {
    logic [31:0]                  src;
    logic [TIME_W-1:0]            ws;
    logic [KINDS-1:0][CNT_W-1:0]  cnt;
  } entry_t;

  typedef struct packed {
    logic [31:0]       src;
    logic [TIME_W-1:0] expiry;
  } gate_t;

  typedef struct packed {
    logic [15:0] open_limit;
    logic [15:0] echo_limit;
    logic [15:0] miss_limit;
    logic [15:0] bad_token_limit;
    logic [15:0] close_limit;
    logic [15:0] window_length;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic hash_item;
    logic claim_load_item;
    logic claim_load_pub;
    logic claim_next_set;
    logic claim_hash;
    logic way_clr;
    logic way_inc;
    logic gate_wr;
    logic block;
    logic probe_clr;
    logic probe_chk;
    logic probe_inc;
    logic take_victim;
    logic restart;
    logic update;
    logic ent_wr;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic kind_none;
    logic kind_gated;
    logic gate_block;
    logic claim_ok;
    logic way_last;
    logic set_last;
    logic probe_hit;
    logic probe_last;
    logic restart;
    logic publish;
    logic item_claim;
  } stat_t;

endpackage

### hdl/psrl_ram.sv
// ---------------------------------------------------------------------------
// psrl_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module psrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/psrl_cfg.sv
// ---------------------------------------------------------------------------
// psrl_cfg
// APB register file holding the limits and the window length.
// ---------------------------------------------------------------------------
module psrl_cfg import psrl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_limit      <= 16'd20;
      cfg.echo_limit      <= 16'd60;
      cfg.miss_limit      <= 16'd2000;
      cfg.bad_token_limit <= 16'd4096;
      cfg.close_limit     <= 16'd4096;
      cfg.window_length   <= 16'd1000;
    end else if (wr) begin
      case (idx)
        REG_OPEN_LIMIT:  cfg.open_limit      <= pwdata[15:0];
        REG_ECHO_LIMIT:  cfg.echo_limit      <= pwdata[15:0];
        REG_MISS_LIMIT:  cfg.miss_limit      <= pwdata[15:0];
        REG_BAD_LIMIT:   cfg.bad_token_limit <= pwdata[15:0];
        REG_CLOSE_LIMIT: cfg.close_limit     <= pwdata[15:0];
        REG_WINDOW_LEN:  cfg.window_length   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_OPEN_LIMIT:  prdata = {16'd0, cfg.open_limit};
      REG_ECHO_LIMIT:  prdata = {16'd0, cfg.echo_limit};
      REG_MISS_LIMIT:  prdata = {16'd0, cfg.miss_limit};
      REG_BAD_LIMIT:   prdata = {16'd0, cfg.bad_token_limit};
      REG_CLOSE_LIMIT: prdata = {16'd0, cfg.close_limit};
      REG_WINDOW_LEN:  prdata = {16'd0, cfg.window_length};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

### hdl/psrl_ctrl.sv
// ---------------------------------------------------------------------------
// psrl_ctrl
// Sequencer: clearing pass, gate check, probing, publishing and update.
// ---------------------------------------------------------------------------
module psrl_ctrl import psrl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [16:0] {
    S_CLEAR  = 17'h00001,
    S_IDLE   = 17'h00002,
    S_HASH   = 17'h00004,
    S_GHASH  = 17'h00008,
    S_GRD    = 17'h00010,
    S_GCK    = 17'h00020,
    S_PSTART = 17'h00040,
    S_PRD    = 17'h00080,
    S_PCK    = 17'h00100,
    S_PVIC   = 17'h00200,
    S_TOUCH  = 17'h00400,
    S_CHASH  = 17'h00800,
    S_CRD    = 17'h01000,
    S_CCK    = 17'h02000,
    S_UPD    = 17'h04000,
    S_EWR    = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  state_t state, state_next;
  logic   pub, pub_next;
  logic   ovalid, ovalid_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = ovalid;

  // state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      pub    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      pub    <= pub_next;
      ovalid <= ovalid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    pub_next    = pub;
    ovalid_next = ovalid && !out_ready;
    cmd         = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_item = 1'b1;
        if (stat.kind_none) begin
          state_next = S_DONE;
        end else if (stat.kind_gated) begin
          cmd.claim_load_item = 1'b1;
          state_next          = S_GHASH;
        end else begin
          state_next = S_PSTART;
        end
      end
      S_GHASH: begin
        cmd.claim_hash = 1'b1;
        cmd.way_clr    = 1'b1;
        state_next     = S_GRD;
      end
      S_GRD: state_next = S_GCK;
      S_GCK: begin
        if (stat.gate_block) begin
          cmd.block  = 1'b1;
          state_next = S_DONE;
        end else if (stat.way_last) begin
          state_next = S_PSTART;
        end else begin
          cmd.way_inc = 1'b1;
          state_next  = S_GRD;
        end
      end
      S_PSTART: begin
        cmd.probe_clr = 1'b1;
        state_next    = S_PRD;
      end
      S_PRD: state_next = S_PCK;
      S_PCK: begin
        cmd.probe_chk = 1'b1;
        if (stat.probe_hit) begin
          state_next = S_TOUCH;
        end else if (stat.probe_last) begin
          state_next = S_PVIC;
        end else begin
          cmd.probe_inc = 1'b1;
          state_next    = S_PRD;
        end
      end
      S_PVIC: begin
        cmd.take_victim = 1'b1;
        state_next      = S_TOUCH;
      end
      S_TOUCH: begin
        if (stat.publish) begin
          cmd.claim_load_pub = 1'b1;
          pub_next           = 1'b1;
          state_next         = S_CHASH;
        end else begin
          cmd.restart = stat.restart;
          state_next  = S_UPD;
        end
      end
      S_CHASH: begin
        cmd.claim_hash = 1'b1;
        cmd.way_clr    = 1'b1;
        state_next     = S_CRD;
      end
      S_CRD: state_next = S_CCK;
      S_CCK: begin
        if (stat.claim_ok || stat.way_last) begin
          cmd.gate_wr = stat.claim_ok;
          if (!pub) begin
            state_next = S_DONE;
          end else if (stat.set_last) begin
            // all three sets claimed: now restart the entry
            cmd.restart = 1'b1;
            pub_next    = 1'b0;
            state_next  = S_UPD;
          end else begin
            cmd.claim_next_set = 1'b1;
            state_next         = S_CHASH;
          end
        end else begin
          cmd.way_inc = 1'b1;
          state_next  = S_CRD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_EWR;
      end
      S_EWR: begin
        cmd.ent_wr = 1'b1;
        if (stat.item_claim) begin
          cmd.claim_load_item = 1'b1;
          state_next          = S_CHASH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_next  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

### hdl/psrl_dp.sv
// ---------------------------------------------------------------------------
// psrl_dp
// Datapath: hash, entry and gate memories, probe and claim registers,
// counter update and result register.
// ---------------------------------------------------------------------------
module psrl_dp import psrl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int SHARD_COUNT   = SHARD_COUNT_DEF,
  parameter int PROBE_DEPTH   = PROBE_DEPTH_DEF,
  parameter int GATE_WAYS     = GATE_WAYS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  item_in_t in_item,
  input  cfg_t     cfg,
  input  cmd_t     cmd,
  output stat_t    stat,
  output result_t  out_item
);

  localparam int TE_W       = $clog2(TABLE_ENTRIES);
  localparam int PER_SHARD  = TABLE_ENTRIES / SHARD_COUNT;
  localparam int GATE_DEPTH = GATE_SETS * TABLE_ENTRIES * GATE_WAYS;
  localparam int GA_W       = $clog2(GATE_DEPTH);
  localparam int WC_W       = $clog2(GATE_WAYS + 1);
  localparam int PC_W       = $clog2(PROBE_DEPTH + 1);
  localparam int ENTRY_W    = $bits(entry_t);
  localparam int GATE_W     = $bits(gate_t);

  // request registers
  logic [2:0]        kind_q;
  logic [31:0]       addr_q;
  logic [TIME_W-1:0] now_q;
  logic [31:0]       prod_q, cprod_q;

  // probe and entry registers
  logic [PC_W-1:0]   pr_q;
  logic              have_old;
  logic [TIME_W-1:0] old_q;
  entry_t            vict_q, ent_q;
  logic [TE_W-1:0]   vidx_q, eidx_q;

  // claim registers
  logic [31:0]       claim_src;
  logic [TIME_W-1:0] claim_until;
  logic [SET_W-1:0]  gset_q;
  logic [WC_W-1:0]   way_q;

  logic [GA_W-1:0]   clr_q;
  logic [1:0]        cause_q;
  logic [31:0]       drop_total;

  // memories
  entry_t          ent_rd, ent_wdata;
  gate_t           gate_rd, gate_wdata;
  logic [TE_W-1:0] eaddr, ewaddr;
  logic [GA_W-1:0] gaddr, gwaddr;
  logic            ewe, gwe;

  // address derivation
  logic [HASH_BITS-1:0] h, gh;
  logic [TE_W-1:0]      shard_base, home;
  logic [31:0]          grow;

  assign h          = prod_q[31 -: HASH_BITS];
  assign gh         = cprod_q[31 -: HASH_BITS];
  assign shard_base = TE_W'(((32'(h) >> SHARD_SHIFT) % SHARD_COUNT) * PER_SHARD);
  assign home       = TE_W'(32'(h) % PER_SHARD);
  assign eaddr      = shard_base + TE_W'((32'(home) + 32'(pr_q)) % PER_SHARD);
  assign grow       = 32'(gset_q) * TABLE_ENTRIES + 32'(gh) % TABLE_ENTRIES;
  assign gaddr      = GA_W'(grow * GATE_WAYS + 32'(way_q));

  // write port muxes: clearing pass or normal update
  assign gwe        = cmd.clear || cmd.gate_wr;
  assign gwaddr     = cmd.clear ? clr_q : gaddr;
  assign gate_wdata = cmd.clear ? gate_t'('0) : gate_t'{src: claim_src, expiry: claim_until};
  assign ewe        = (cmd.clear && (32'(clr_q) < TABLE_ENTRIES)) || cmd.ent_wr;
  assign ewaddr     = cmd.clear ? clr_q[TE_W-1:0] : eidx_q;
  assign ent_wdata  = cmd.clear ? entry_t'('0) : ent_q;

  psrl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ewe),
    .waddr (ewaddr),
    .wdata (ent_wdata),
    .raddr (eaddr),
    .rdata (ent_rd)
  );

  psrl_ram #(.WIDTH(GATE_W), .DEPTH(GATE_DEPTH)) u_gate_ram (
    .clk   (clk),
    .we    (gwe),
    .waddr (gwaddr),
    .wdata (gate_wdata),
    .raddr (gaddr),
    .rdata (gate_rd)
  );

  // window checks on the working entry
  logic [TIME_W-1:0] age;
  logic              expired;
  logic [TIME_W:0]   until_sum;
  logic [TIME_W-1:0] until_sat;

  assign age       = now_q - ent_q.ws;
  assign expired   = (now_q < ent_q.ws) || (age >= TIME_W'(cfg.window_length));
  assign until_sum = {1'b0, ent_q.ws} + (TIME_W + 1)'(cfg.window_length);
  assign until_sat = until_sum[TIME_W] ? TIME_MAX : until_sum[TIME_W-1:0];

  // counter of the current kind
  logic [2:0]       kidx;
  logic [CNT_W-1:0] cur_cnt, inc_cnt;
  logic [15:0]      lim;

  assign kidx    = (kind_q <= KIND_CLOSE) ? kind_q : KIND_OPEN;
  assign cur_cnt = ent_q.cnt[kidx];
  assign inc_cnt = (cur_cnt != CNT_MAX) ? cur_cnt + CNT_W'(1) : cur_cnt;

  always_comb begin
    case (kind_q)
      KIND_OPEN:             lim = cfg.open_limit;
      KIND_PING, KIND_ECHO:  lim = cfg.echo_limit;
      KIND_MISS:             lim = cfg.miss_limit;
      KIND_BAD:              lim = cfg.bad_token_limit;
      KIND_CLOSE:            lim = cfg.close_limit;
      default:               lim = 16'd0;
    endcase
  end

  // status to the controller
  logic probe_hit;
  assign probe_hit = (ent_rd.src == addr_q) || (ent_rd.src == 32'd0 && ent_rd.ws == '0);

  always_comb begin
    stat.clr_last   = (32'(clr_q) == GATE_DEPTH - 1);
    stat.kind_none  = (kind_q > KIND_CLOSE);
    stat.kind_gated = (kind_q >= KIND_MISS);
    stat.gate_block = (gate_rd.src == addr_q) && (gate_rd.expiry > now_q);
    stat.claim_ok   = (gate_rd.src == 32'd0) || (gate_rd.src == claim_src) ||
                      (gate_rd.expiry <= now_q);
    stat.way_last   = (32'(way_q) == GATE_WAYS - 1);
    stat.set_last   = (32'(gset_q) == GATE_SETS - 1);
    stat.probe_hit  = probe_hit;
    stat.probe_last = (32'(pr_q) == PROBE_DEPTH - 1);
    stat.restart    = (ent_q.src != addr_q) || expired;
    stat.publish    = (ent_q.src != 32'd0) && !expired && (ent_q.src != addr_q) &&
                      (|ent_q.cnt);
    stat.item_claim = (cause_q == CAUSE_WINDOW) && (kind_q >= KIND_MISS);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_q      <= '0;
      drop_total <= 32'd0;
    end else begin
      if (cmd.clear) clr_q <= clr_q + GA_W'(1);
      if (cmd.update && kind_q <= KIND_ECHO && cur_cnt >= CNT_W'(lim) &&
          drop_total != DROP_MAX) begin
        drop_total <= drop_total + 32'd1;
      end
    end
  end

  // request capture and hashing
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= in_item.kind;
      addr_q <= in_item.source_addr;
      now_q  <= in_item.timestamp;
    end
    if (cmd.hash_item) prod_q <= addr_q * HASH_MUL;
    if (cmd.claim_hash) cprod_q <= claim_src * HASH_MUL;
  end

  // claim setup and way walk
  always_ff @(posedge clk) begin
    if (cmd.claim_load_item) begin
      claim_src   <= addr_q;
      claim_until <= until_sat;
      gset_q      <= SET_W'(kind_q - KIND_MISS);
    end else if (cmd.claim_load_pub) begin
      claim_src   <= ent_q.src;
      claim_until <= until_sat;
      gset_q      <= '0;
    end else if (cmd.claim_next_set) begin
      gset_q <= gset_q + SET_W'(1);
    end
    if (cmd.way_clr) begin
      way_q <= '0;
    end else if (cmd.way_inc) begin
      way_q <= way_q + WC_W'(1);
    end
  end

  // probing and working entry
  always_ff @(posedge clk) begin
    if (cmd.probe_clr) begin
      pr_q     <= '0;
      have_old <= 1'b0;
    end else if (cmd.probe_inc) begin
      pr_q <= pr_q + PC_W'(1);
    end
    if (cmd.probe_chk) begin
      // oldest window so far, first one wins a tie
      if (!have_old || ent_rd.ws < old_q) begin
        have_old <= 1'b1;
        old_q    <= ent_rd.ws;
        vict_q   <= ent_rd;
        vidx_q   <= eaddr;
      end
      if (probe_hit) begin
        ent_q  <= ent_rd;
        eidx_q <= eaddr;
      end
    end else if (cmd.take_victim) begin
      ent_q  <= vict_q;
      eidx_q <= vidx_q;
    end else if (cmd.restart) begin
      ent_q.src <= addr_q;
      ent_q.ws  <= now_q;
      ent_q.cnt <= '0;
    end else if (cmd.update) begin
      if (kind_q <= KIND_ECHO) begin
        if (cur_cnt < CNT_W'(lim)) ent_q.cnt[kidx] <= inc_cnt;
      end else begin
        ent_q.cnt[kidx] <= inc_cnt;
      end
    end
  end

  // deny cause
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cause_q <= CAUSE_NONE;
    end else if (cmd.block) begin
      cause_q <= CAUSE_GATE;
    end else if (cmd.update) begin
      if (kind_q <= KIND_ECHO) begin
        if (cur_cnt >= CNT_W'(lim)) cause_q <= CAUSE_WINDOW;
      end else if (inc_cnt > CNT_W'(lim)) begin
        cause_q <= CAUSE_WINDOW;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.allowed      <= (cause_q == CAUSE_NONE);
      out_item.deny_cause   <= cause_q;
      out_item.drops_so_far <= drop_total;
    end
  end

endmodule

### hdl/per_source_window_rate_limiter.sv
// ---------------------------------------------------------------------------
// per_source_window_rate_limiter
// Per-source fixed-window rate limiter with hashed entry table and gates.
// ---------------------------------------------------------------------------
// One request is worked on at a time. After reset the block runs a clearing
// pass over all 3*TABLE_ENTRIES*GATE_WAYS gate words (49152 by default), which
// also clears the entry table, before in_ready rises. A request is then hashed;
// for gated kinds up to GATE_WAYS gate ways are scanned, then up to
// PROBE_DEPTH entries are probed, the oldest being taken when none hits.
// Each gate claim scans up to GATE_WAYS ways; a publishing eviction makes
// three claims. A request blocked by a gate skips the probing, an unknown
// kind goes straight to its result. Entry and gate memories each have a
// single read port, read one word per step. A finished result waits in the
// output register while the next request is taken.
module per_source_window_rate_limiter import psrl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int SHARD_COUNT   = SHARD_COUNT_DEF,
  parameter int PROBE_DEPTH   = PROBE_DEPTH_DEF,
  parameter int GATE_WAYS     = GATE_WAYS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_in_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  psrl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psrl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SHARD_COUNT   (SHARD_COUNT),
    .PROBE_DEPTH   (PROBE_DEPTH),
    .GATE_WAYS     (GATE_WAYS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  // an accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // no request is taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !in_ready)
    else $error("ready during clearing pass");

  // allowed flag agrees with the deny cause
  a_allowed_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.allowed == (out_item.deny_cause == CAUSE_NONE)))
    else $error("allowed flag and cause disagree");

  // gate claim writes never coincide with entry writes or the clearing pass
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    cmd.gate_wr |-> !cmd.ent_wr && !cmd.clear)
    else $error("conflicting memory writes");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives random and directed requests into the per-source window rate
// limiter, predicts every verdict with its own table, gate and counter
// model, and compares each result field by field. Limits and window length
// are changed over APB between traffic phases, extremes included.
// ---------------------------------------------------------------------------
module testbench;
  import psrl_pkg::*;

  localparam int N_ENT     = TABLE_ENTRIES_DEF;
  localparam int N_SHARD   = SHARD_COUNT_DEF;
  localparam int PER_SHARD = N_ENT / N_SHARD;
  localparam int N_PROBE   = PROBE_DEPTH_DEF;
  localparam int N_WAYS    = GATE_WAYS_DEF;
  localparam int N_GATE    = GATE_SETS * N_ENT * N_WAYS;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  item_in_t           in_item;
  logic               out_valid;
  logic               out_ready;
  result_t            out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  per_source_window_rate_limiter u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [31:0]       ent_src   [N_ENT];
  logic [TIME_W-1:0] ent_start [N_ENT];
  logic [CNT_W-1:0]  ent_cnt   [N_ENT][KINDS];
  logic [31:0]       gate_src  [N_GATE];
  logic [TIME_W-1:0] gate_until[N_GATE];
  logic [31:0]       drop_count;
  logic [15:0]       limit_reg [6];

  item_in_t pending_reqs[$];
  result_t  expected_verdicts[$];
  int       n_errors;
  int       n_accepted;

  // addresses that crowd one shard neighborhood, to force probing and eviction
  logic [31:0] crowd_addr[$];
  logic [31:0] light_addr[16];
  logic [TIME_W-1:0] now_ms;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [9:0] addr_hash(logic [31:0] a);
    logic [31:0] p;
    p = a * HASH_MUL;
    return p[31:HASH_SHIFT];
  endfunction

  function automatic logic [TIME_W-1:0] window_end(logic [TIME_W-1:0] ws);
    logic [63:0] u;
    u = 64'(ws) + 64'(limit_reg[REG_WINDOW_LEN]);
    return (u > 64'(TIME_MAX)) ? TIME_MAX : u[TIME_W-1:0];
  endfunction

  function automatic int gate_base(int set, logic [31:0] a);
    return (set * N_ENT + int'(addr_hash(a))) * N_WAYS;
  endfunction

  function automatic void gate_claim(int set, logic [31:0] a, logic [TIME_W-1:0] till,
                                     logic [TIME_W-1:0] now);
    int g;
    for (int w = 0; w < N_WAYS; w++) begin
      g = gate_base(set, a) + w;
      if (gate_src[g] != 0 && gate_src[g] != a && gate_until[g] > now) continue;
      gate_src[g]   = a;
      gate_until[g] = till;
      return;
    end
  endfunction

  function automatic bit gate_holds(int set, logic [31:0] a, logic [TIME_W-1:0] now);
    int g;
    for (int w = 0; w < N_WAYS; w++) begin
      g = gate_base(set, a) + w;
      if (gate_src[g] == a && gate_until[g] > now) return 1'b1;
    end
    return 1'b0;
  endfunction

  // linear probe inside the shard, oldest window as victim
  function automatic int find_entry(logic [31:0] a);
    logic [9:0]  h;
    logic [63:0] oldest;
    int base, home, victim, e;
    h = addr_hash(a);
    base = ((int'(h) >> SHARD_SHIFT) % N_SHARD) * PER_SHARD;
    home = int'(h) % PER_SHARD;
    victim = 0;
    oldest = '1;
    for (int i = 0; i < N_PROBE; i++) begin
      e = base + (home + i) % PER_SHARD;
      if (64'(ent_start[e]) < oldest) begin
        oldest = 64'(ent_start[e]);
        victim = i;
      end
      if (ent_src[e] == a || (ent_src[e] == 0 && ent_start[e] == 0)) return e;
    end
    return base + (home + victim) % PER_SHARD;
  endfunction

  // restart on new source or expired window, publishing a live victim first
  function automatic int touch_entry(logic [31:0] a, logic [TIME_W-1:0] now);
    int e;
    logic [63:0] age;
    logic [31:0] s;
    bit busy;
    e = find_entry(a);
    age = 64'(now) - 64'(ent_start[e]);
    if (ent_src[e] != a || age >= 64'(limit_reg[REG_WINDOW_LEN])) begin
      s = ent_src[e];
      busy = 1'b0;
      for (int k = 0; k < KINDS; k++) if (ent_cnt[e][k] != 0) busy = 1'b1;
      if (s != 0 && age < 64'(limit_reg[REG_WINDOW_LEN]) && busy)
        for (int k = 0; k < GATE_SETS; k++) gate_claim(k, s, window_end(ent_start[e]), now);
      ent_src[e] = a;
      ent_start[e] = now;
      for (int k = 0; k < KINDS; k++) ent_cnt[e][k] = '0;
    end
    return e;
  endfunction

  function automatic logic [15:0] kind_limit(logic [2:0] kind);
    case (kind)
      KIND_OPEN: return limit_reg[REG_OPEN_LIMIT];
      KIND_PING, KIND_ECHO: return limit_reg[REG_ECHO_LIMIT];
      KIND_MISS: return limit_reg[REG_MISS_LIMIT];
      KIND_BAD: return limit_reg[REG_BAD_LIMIT];
      default: return limit_reg[REG_CLOSE_LIMIT];
    endcase
  endfunction

  function automatic result_t predict_verdict(item_in_t r);
    result_t v;
    logic [1:0] cause;
    int e, k, set;
    cause = CAUSE_NONE;
    k = int'(r.kind);
    if (r.kind <= KIND_ECHO) begin
      e = touch_entry(r.source_addr, r.timestamp);
      if (ent_cnt[e][k] >= 17'(kind_limit(r.kind))) begin
        cause = CAUSE_WINDOW;
        if (drop_count != DROP_MAX) drop_count++;
      end else if (ent_cnt[e][k] != CNT_MAX) begin
        ent_cnt[e][k]++;
      end
    end else if (r.kind <= KIND_CLOSE) begin
      set = k - int'(KIND_MISS);
      if (gate_holds(set, r.source_addr, r.timestamp)) begin
        cause = CAUSE_GATE;
      end else begin
        e = touch_entry(r.source_addr, r.timestamp);
        if (ent_cnt[e][k] != CNT_MAX) ent_cnt[e][k]++;
        if (ent_cnt[e][k] > 17'(kind_limit(r.kind))) begin
          cause = CAUSE_WINDOW;
          gate_claim(set, r.source_addr, window_end(ent_start[e]), r.timestamp);
        end
      end
    end
    v.allowed = (cause == CAUSE_NONE);
    v.deny_cause = cause;
    v.drops_so_far = drop_count;
    return v;
  endfunction

  task automatic report(string what, result_t got, result_t want);
    $display("mismatch %s at %0t: got %0d/%0d/%0d want %0d/%0d/%0d", what, $realtime,
             got.allowed, got.deny_cause, got.drops_so_far,
             want.allowed, want.deny_cause, want.drops_so_far);
    n_errors++;
  endtask

  // request driver: bursts with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        in_item <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  int stall_mode;
  int mode_left;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= 400) begin
      out_ready <= 1'b0;
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // accepted requests feed the predictor; results are checked in order
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_verdicts.push_back(predict_verdict(in_item));
      n_accepted <= n_accepted + 1;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report("unexpected result", out_item, '0);
      end else begin
        result_t want;
        want = expected_verdicts.pop_front();
        if (out_item.allowed !== want.allowed) report("allowed", out_item, want);
        if (out_item.deny_cause !== want.deny_cause) report("deny_cause", out_item, want);
        if (out_item.drops_so_far !== want.drops_so_far) report("drops_so_far", out_item, want);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg[idx] = value;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic void queue_req(logic [2:0] kind, logic [31:0] a, logic [TIME_W-1:0] ts);
    item_in_t r;
    r.kind = kind;
    r.source_addr = a;
    r.timestamp = ts;
    pending_reqs.push_back(r);
  endfunction

  // random traffic around a crowded shard with a slowly advancing clock
  task automatic random_phase(int count);
    logic [31:0] a;
    logic [2:0]  kind;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) a = crowd_addr[$urandom_range(0, crowd_addr.size() - 1)];
      else if (pick < 90) a = light_addr[$urandom_range(0, 15)];
      else a = $urandom();
      kind = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      pick = $urandom_range(0, 99);
      if (pick < 2) now_ms = {$urandom(), 16'($urandom())};
      else if (pick < 4) now_ms = now_ms - 48'($urandom_range(0, 100));
      else now_ms = now_ms + 48'($urandom_range(0, int'(limit_reg[REG_WINDOW_LEN]) / 6 + 1));
      queue_req(kind, a, now_ms);
    end
  endtask

  task automatic set_limits(logic [15:0] o, logic [15:0] e, logic [15:0] m,
                            logic [15:0] b, logic [15:0] c, logic [15:0] w);
    reg_write(REG_OPEN_LIMIT, o);
    reg_write(REG_ECHO_LIMIT, e);
    reg_write(REG_MISS_LIMIT, m);
    reg_write(REG_BAD_LIMIT, b);
    reg_write(REG_CLOSE_LIMIT, c);
    reg_write(REG_WINDOW_LEN, w);
  endtask

  initial begin
    logic [31:0] a;
    logic [9:0]  h;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_item = '0;
    n_errors = 0;
    n_accepted = 0;
    drop_count = '0;
    now_ms = 48'd100;
    for (int i = 0; i < N_ENT; i++) begin
      ent_src[i] = '0;
      ent_start[i] = '0;
      for (int k = 0; k < KINDS; k++) ent_cnt[i][k] = '0;
    end
    for (int i = 0; i < N_GATE; i++) begin
      gate_src[i] = '0;
      gate_until[i] = '0;
    end
    limit_reg[REG_OPEN_LIMIT] = 16'd20;
    limit_reg[REG_ECHO_LIMIT] = 16'd60;
    limit_reg[REG_MISS_LIMIT] = 16'd2000;
    limit_reg[REG_BAD_LIMIT] = 16'd4096;
    limit_reg[REG_CLOSE_LIMIT] = 16'd4096;
    limit_reg[REG_WINDOW_LEN] = 16'd1000;
    // twelve sources hashing into the first few homes of one shard
    while (crowd_addr.size() < 12) begin
      a = $urandom();
      h = addr_hash(a);
      if (h[9:6] == 4'd3 && h[5:0] < 6'd3) crowd_addr.push_back(a);
    end
    for (int i = 0; i < 16; i++) light_addr[i] = $urandom();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of every field, every kind, unknown kinds
    set_limits(16'd3, 16'd2, 16'd2, 16'd1, 16'd3, 16'd40);
    for (int k = 0; k < 8; k++) queue_req(3'(k), 32'h0, 48'h0);
    for (int k = 0; k < 6; k++) queue_req(3'(k), 32'hFFFF_FFFF, TIME_MAX);
    for (int k = 0; k < 4; k++) queue_req(KIND_BAD, 32'hFFFF_FFFF, TIME_MAX);
    queue_req(KIND_OPEN, 32'hFFFF_FFFF, 48'd5);
    for (int k = 0; k < 4; k++) queue_req(KIND_OPEN, crowd_addr[0], 48'd50);
    queue_req(KIND_OPEN, crowd_addr[0], 48'd90);
    random_phase(320);
    wait_drained();

    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(250);
    wait_drained();

    set_limits(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    random_phase(250);
    wait_drained();

    // zero limits and zero window length
    set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(150);
    wait_drained();

    set_limits(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
               16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
               16'($urandom_range(1, 6)), 16'($urandom_range(5, 200)));
    random_phase(520);
    wait_drained();

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
